[hw/rtl/u8u7_pkg.sv]
`default_nettype none

package u8u7_pkg;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // ASCII codes with special meaning in UTF-7.
  localparam logic [6:0] CH_LF     = 7'h0A;
  localparam logic [6:0] CH_CR     = 7'h0D;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_PLUS   = 7'h2B;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_SLASH  = 7'h2F;
  localparam logic [6:0] CH_EQUALS = 7'h3D;
  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_TILDE  = 7'h7E;

  // What the back has to do with one queued request.
  typedef enum logic [2:0] {
    OP_NONE,    // end of stream only
    OP_DIRECT,  // character sent as itself
    OP_PLUS,    // '+' : "+-" outside a run, a unit inside one
    OP_UNIT,    // one 16-bit unit into base64
    OP_PAIR     // surrogate pair
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [6:0]  ch;       // direct character
    logic        dash;     // direct char needs '-' before it when closing a run
    logic [15:0] u0;
    logic [15:0] u1;
    logic        do_end;   // flush and close after this request
    logic        op_last;  // final request of its input byte
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIRECT,
    BK_PLUS,
    BK_DASH,
    BK_UNIT0,
    BK_UNIT1,
    BK_END
  } back_state_e;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    begin
      w = {1'b0, v};
      if (v < 6'd26) begin
        c = w + 7'h41;
      end else if (v < 6'd52) begin
        c = w + 7'h47;
      end else if (v < 6'd62) begin
        c = w - 7'h04;
      end else if (v == 6'd62) begin
        c = CH_PLUS;
      end else begin
        c = CH_SLASH;
      end
      return c;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/utf8_to_utf7_encoder.sv]
// UTF-8 to UTF-7 stream encoder. Bytes enter on the in_* request channel with
// in_last_i on the final byte of a string; UTF-7 characters leave on the out_*
// channel, out_last_o set on the final character caused by an input byte (a
// byte that only buffers a continuation causes none). The front decodes and
// classifies each byte and queues at most one request per byte, except that a
// last byte cutting a sequence short queues up to three (the lead, then one or
// two re-parsed codes); the back turns requests into characters, one character
// per cycle while the output is not stalled, into a registered output stage.
// A plain ASCII byte costs a request fetch plus the character; each further
// character (escape dash, run opener, base64 digit) adds to that, and a base64
// group is four digits. A last byte that ends a sequence cut short holds the
// input off while its re-parsed codes (one or two) are queued, and longer while
// the request queue is full. Throughput is set by the back sequencer's one
// character per cycle while the output is not stalled; a two-entry request
// queue lets the front run ahead.
`default_nettype none

module utf8_to_utf7_encoder import u8u7_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      out_char_o,
  output logic            out_last_o
);

  // request queue between front and back
  logic q_push, q_full, q_pop, q_valid;
  op_t  q_push_op, q_op;

  // front: UTF-8 sequence tracking, code point decode, request classification
  u8u7_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (q_push),
    .push_op_o  (q_push_op),
    .full_i     (q_full)
  );

  u8u7_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .op_o      (q_op)
  );

  // back: base64 packing, run open/close, output register
  u8u7_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

  // never write a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("request queue overrun");

  // never read an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("request queue underrun");

  // end-of-stream work always rides on the final request of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_push_op.do_end) |-> q_push_op.op_last)
    else $error("end of stream on a non-final request");

  // input is held off while cut-short leftovers are being queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_push_op.op_last) |=> !in_ready_o)
    else $error("input accepted during re-parse");

endmodule

`default_nettype wire

[hw/rtl/u8u7_queue.sv]
`default_nettype none

module u8u7_queue import u8u7_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       op_o
);

  op_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/u8u7_front.sv]
`default_nettype none

module u8u7_front import u8u7_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            push_o,
  output op_t             push_op_o,
  input  wire logic       full_i
);

  function automatic logic [1:0] cont_count(input logic [7:0] b);
    logic [1:0] n;
    begin
      if (b <= 8'h7F) begin
        n = 2'd0;
      end else if (b <= 8'hDF) begin
        n = 2'd1;
      end else if (b <= 8'hEF) begin
        n = 2'd2;
      end else begin
        n = 2'd3;
      end
      return n;
    end
  endfunction

  function automatic logic is_b64(input logic [6:0] c);
    begin
      return (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
             (c >= 7'h30 && c <= 7'h39) || c == CH_PLUS || c == CH_SLASH;
    end
  endfunction

  function automatic op_t classify(input logic [20:0] cp);
    op_t        o;
    logic [20:0] v;
    logic [6:0]  c;
    logic        direct;
    begin
      o      = '0;
      c      = cp[6:0];
      v      = cp - 21'h010000;
      direct = (cp < 21'd127) && c != CH_LF && c != CH_CR && c != CH_BSLASH &&
               c != CH_TILDE && c != CH_PLUS && c != CH_EQUALS && c != CH_DQUOTE;
      o.ch   = c;
      o.dash = is_b64(c) || (c == CH_DASH);
      o.kind = OP_UNIT;
      o.u0   = cp[15:0];
      if (direct) begin
        o.kind = OP_DIRECT;
      end else if (cp == {14'd0, CH_PLUS}) begin
        o.kind = OP_PLUS;
      end else if (cp > 21'h10FFFF) begin
        o.u0 = 16'hFFFD;
      end else if (cp >= 21'h010000) begin
        o.kind = OP_PAIR;
        o.u0   = {6'b110110, v[19:10]};
        o.u1   = {6'b110111, v[9:0]};
      end
      return o;
    end
  endfunction

  logic [1:0]  seq_needed_q, seq_needed_d;
  logic [1:0]  seq_have_q, seq_have_d;
  logic [7:0]  sb0_q, sb0_d, sb1_q, sb1_d, sb2_q, sb2_d;
  logic [10:0] rem0_q, rem0_d, rem1_q, rem1_d;
  logic [1:0]  rem_cnt_q, rem_cnt_d;

  logic        rem_busy, acc, complete;
  logic        have_code, pend_lead, buffering, none_op;
  logic        op_last, do_end;
  logic [1:0]  cc_b;
  logic [20:0] cp, dec;
  op_t         op;

  assign rem_busy   = (rem_cnt_q != 2'd0);
  assign in_ready_o = !full_i && !rem_busy;
  assign acc        = in_valid_i && in_ready_o;
  assign cc_b       = cont_count(in_byte_i);
  assign complete   = (seq_needed_q != 2'd0) &&
                      (({1'b0, seq_have_q} + 3'd1) >= {1'b0, seq_needed_q});

  always_comb begin
    case (seq_needed_q)
      2'd1:    dec = {10'd0, sb0_q[4:0], in_byte_i[5:0]};
      2'd2:    dec = {5'd0, sb0_q[3:0], sb1_q[5:0], in_byte_i[5:0]};
      default: dec = {sb0_q[2:0], sb1_q[5:0], sb2_q[5:0], in_byte_i[5:0]};
    endcase
  end

  always_comb begin
    seq_needed_d = seq_needed_q;
    seq_have_d   = seq_have_q;
    sb0_d        = sb0_q;
    sb1_d        = sb1_q;
    sb2_d        = sb2_q;
    rem0_d       = rem0_q;
    rem1_d       = rem1_q;
    rem_cnt_d    = rem_cnt_q;
    have_code    = 1'b0;
    pend_lead    = 1'b0;
    buffering    = 1'b0;
    none_op      = 1'b0;
    push_o       = 1'b0;
    cp           = '0;
    op_last      = 1'b0;
    do_end       = 1'b0;

    if (rem_busy) begin
      // leftover codes of a sequence cut short by the end of stream
      if (!full_i) begin
        push_o    = 1'b1;
        cp        = {10'd0, rem0_q};
        op_last   = (rem_cnt_q == 2'd1);
        do_end    = (rem_cnt_q == 2'd1);
        rem0_d    = rem1_q;
        rem_cnt_d = rem_cnt_q - 2'd1;
      end
    end else if (acc) begin
      if (seq_needed_q == 2'd0) begin
        if (cc_b == 2'd0) begin
          have_code = 1'b1;
          cp        = {13'd0, in_byte_i};
        end else begin
          sb0_d        = in_byte_i;
          seq_needed_d = cc_b;
          seq_have_d   = 2'd0;
          pend_lead    = 1'b1;
        end
      end else if (complete) begin
        have_code    = 1'b1;
        cp           = dec;
        seq_needed_d = 2'd0;
        seq_have_d   = 2'd0;
      end else begin
        if (seq_have_q[0]) begin
          sb2_d = in_byte_i;
        end else begin
          sb1_d = in_byte_i;
        end
        seq_have_d = seq_have_q + 2'd1;
        buffering  = 1'b1;
      end

      if (!in_last_i) begin
        push_o  = have_code;
        op_last = 1'b1;
      end else begin
        push_o       = 1'b1;
        op_last      = 1'b1;
        do_end       = 1'b1;
        seq_needed_d = 2'd0;
        seq_have_d   = 2'd0;
        if (pend_lead) begin
          cp = {13'd0, in_byte_i};
        end else if (buffering) begin
          // lead byte goes out alone, the rest is parsed again
          cp      = {13'd0, sb0_q};
          op_last = 1'b0;
          do_end  = 1'b0;
          if (seq_have_q == 2'd0) begin
            rem0_d    = {3'd0, in_byte_i};
            rem_cnt_d = 2'd1;
          end else if (cont_count(sb1_q) == 2'd1) begin
            rem0_d    = {sb1_q[4:0], in_byte_i[5:0]};
            rem_cnt_d = 2'd1;
          end else begin
            rem0_d    = {3'd0, sb1_q};
            rem1_d    = {3'd0, in_byte_i};
            rem_cnt_d = 2'd2;
          end
        end else if (!have_code) begin
          none_op = 1'b1;
        end
      end
    end

    op         = classify(cp);
    if (none_op) begin
      op.kind = OP_NONE;
    end
    op.op_last = op_last;
    op.do_end  = do_end;
    push_op_o  = op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_needed_q <= 2'd0;
      seq_have_q   <= 2'd0;
      rem_cnt_q    <= 2'd0;
    end else begin
      seq_needed_q <= seq_needed_d;
      seq_have_q   <= seq_have_d;
      rem_cnt_q    <= rem_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sb0_q  <= sb0_d;
    sb1_q  <= sb1_d;
    sb2_q  <= sb2_d;
    rem0_q <= rem0_d;
    rem1_q <= rem1_d;
  end

endmodule

`default_nettype wire

[hw/rtl/u8u7_back.sv]
`default_nettype none

module u8u7_back import u8u7_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire op_t  q_op_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [6:0] out_char_o,
  output logic      out_last_o
);

  back_state_e state_q, state_d;
  op_t         cur_q, cur_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  hb_q, hb_d;
  logic        run_q, run_d;
  logic [17:0] sr_q, sr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        fin_q, fin_d;
  logic        ov_q;
  logic [6:0]  oc_q;
  logic        ol_q;

  logic        can_emit, emit, emit_last, load;
  logic [6:0]  emit_char;
  logic [23:0] word, flush_word;
  logic        more_units, final_u;
  logic [15:0] unit;

  assign can_emit   = !ov_q || out_ready_i;
  assign flush_word = (hb_q == 2'd2) ? {held_q, 8'h00} : {held_q[7:0], 16'h0000};
  assign unit       = (state_q == BK_UNIT1) ? cur_q.u1 : cur_q.u0;
  assign more_units = (state_q == BK_UNIT0) && (cur_q.kind == OP_PAIR);
  // chars of this unit end the request unless more output follows
  assign final_u    = !cur_q.do_end && (!more_units || hb_q == 2'd1);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    held_d    = held_q;
    hb_d      = hb_q;
    run_d     = run_q;
    sr_d      = sr_q;
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_char = '0;
    emit_last = 1'b0;
    load      = 1'b0;
    word      = flush_word;

    if (cnt_q != 2'd0) begin
      // drain a base64 group
      if (can_emit) begin
        emit      = 1'b1;
        emit_char = b64_char(sr_q[17:12]);
        sr_d      = {sr_q[11:0], 6'd0};
        cnt_d     = cnt_q - 2'd1;
        emit_last = (cnt_q == 2'd1) && fin_q && cur_q.op_last;
      end
    end else begin
      case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            cur_d   = q_op_i;
            case (q_op_i.kind)
              OP_DIRECT: state_d = BK_DIRECT;
              OP_PLUS:   state_d = run_q ? BK_UNIT0 : BK_PLUS;
              OP_UNIT:   state_d = BK_UNIT0;
              OP_PAIR:   state_d = BK_UNIT0;
              OP_NONE:   state_d = BK_END;
              default:   state_d = BK_IDLE;
            endcase
          end
        end
        BK_DIRECT: begin
          if (can_emit) begin
            if (hb_q != 2'd0) begin
              load   = 1'b1;
              fin_d  = 1'b0;
              held_d = '0;
              hb_d   = 2'd0;
            end else if (run_q && cur_q.dash) begin
              emit      = 1'b1;
              emit_char = CH_DASH;
              run_d     = 1'b0;
            end else begin
              emit      = 1'b1;
              emit_char = cur_q.ch;
              emit_last = cur_q.op_last;
              run_d     = 1'b0;
              state_d   = BK_IDLE;
            end
          end
        end
        BK_PLUS: begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_char = CH_PLUS;
            state_d   = BK_DASH;
          end
        end
        BK_DASH: begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_char = CH_DASH;
            emit_last = cur_q.op_last;
            state_d   = BK_IDLE;
          end
        end
        BK_UNIT0, BK_UNIT1: begin
          if (can_emit) begin
            case (hb_q)
              2'd0: begin
                held_d = unit;
                hb_d   = 2'd2;
                if (!run_q) begin
                  emit      = 1'b1;
                  emit_char = CH_PLUS;
                  emit_last = final_u && cur_q.op_last;
                  run_d     = 1'b1;
                end
              end
              2'd2: begin
                word   = {held_q, unit[15:8]};
                load   = 1'b1;
                fin_d  = final_u;
                held_d = {8'h00, unit[7:0]};
                hb_d   = 2'd1;
              end
              default: begin
                word   = {held_q[7:0], unit};
                load   = 1'b1;
                fin_d  = final_u;
                held_d = '0;
                hb_d   = 2'd0;
              end
            endcase
            if (more_units) begin
              state_d = BK_UNIT1;
            end else if (cur_q.do_end) begin
              state_d = BK_END;
            end else begin
              state_d = BK_IDLE;
            end
          end
        end
        BK_END: begin
          if (can_emit) begin
            if (hb_q != 2'd0) begin
              load   = 1'b1;
              fin_d  = 1'b0;
              held_d = '0;
              hb_d   = 2'd0;
            end else if (run_q) begin
              emit      = 1'b1;
              emit_char = CH_DASH;
              emit_last = cur_q.op_last;
              run_d     = 1'b0;
              state_d   = BK_IDLE;
            end else begin
              state_d = BK_IDLE;
            end
          end
        end
        default: state_d = BK_IDLE;
      endcase

      if (load) begin
        // first char of the group goes out now, three follow
        emit      = 1'b1;
        emit_char = b64_char(word[23:18]);
        emit_last = 1'b0;
        sr_d      = word[17:0];
        cnt_d     = 2'd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      held_q  <= '0;
      hb_q    <= 2'd0;
      run_q   <= 1'b0;
      cnt_q   <= 2'd0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      hb_q    <= hb_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    sr_q  <= sr_d;
    if (emit) begin
      oc_q <= emit_char;
      ol_q <= emit_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;

endmodule

`default_nettype wire

[tb/utf8_to_utf7_encoder_tb.sv]
`timescale 1ns / 1ps

module utf8_to_utf7_encoder_tb;
  import u8u7_pkg::*;

  // Sim time before the watchdog ends the run, in ns.
  localparam int unsigned TIMEOUT_NS   = 2000000;
  // Cycles to let pass once nothing is expected: covers the request queue
  // plus the back sequencer finishing a four-digit group.
  localparam int unsigned SETTLE_CYC   = 32;
  // Random bytes per idling phase.
  localparam int unsigned PHASE_BYTES  = 100;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_last;
  } utf7_char_t;

  // Expected UTF-7 characters, worked out one input byte at a time.
  class utf7_char_scoreboard;
    logic [7:0]  seq_lead_cont[3];   // lead byte, then continuation bytes
    int          cont_needed;
    int          cont_have;
    logic [15:0] held_bits;
    int          held_bytes;
    bit          in_run;
    utf7_char_t  expected_chars[$];
    utf7_char_t  step_chars[$];
    string       b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    int          errors = 0;

    function new();
      seq_lead_cont = '{8'h00, 8'h00, 8'h00};
      cont_needed = 0;
      cont_have   = 0;
      held_bits   = '0;
      held_bytes  = 0;
      in_run      = 1'b0;
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction

    // A single byte never causes more than 24 characters.
    function void push_char(logic [6:0] c);
      if (step_chars.size() < 24) step_chars.push_back('{ch: c, is_last: 1'b0});
    endfunction

    function void push_group(logic [23:0] v);
      push_char(7'(b64_alphabet[v[23:18]]));
      push_char(7'(b64_alphabet[v[17:12]]));
      push_char(7'(b64_alphabet[v[11:6]]));
      push_char(7'(b64_alphabet[v[5:0]]));
    endfunction

    function bit is_b64(logic [20:0] c);
      return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
             (c >= 21'h30 && c <= 21'h39) || c == CH_PLUS || c == CH_SLASH;
    endfunction

    function bit is_direct(logic [20:0] c);
      return c < 21'h7F && c != CH_LF && c != CH_CR && c != CH_BSLASH &&
             c != CH_TILDE && c != CH_PLUS && c != CH_EQUALS && c != CH_DQUOTE;
    endfunction

    function void flush_held();
      if (held_bytes == 2) push_group({held_bits, 8'h00});
      else if (held_bytes == 1) push_group({held_bits[7:0], 16'h0000});
      held_bits  = '0;
      held_bytes = 0;
    endfunction

    function void put_unit(logic [15:0] u);
      if (held_bytes == 0) begin
        if (!in_run) begin
          push_char(CH_PLUS);
          in_run = 1'b1;
        end
        held_bits  = u;
        held_bytes = 2;
      end else if (held_bytes == 2) begin
        push_group({held_bits, u[15:8]});
        held_bits  = {8'h00, u[7:0]};
        held_bytes = 1;
      end else begin
        push_group({held_bits[7:0], u});
        held_bits  = '0;
        held_bytes = 0;
      end
    endfunction

    function void put_code(logic [20:0] cp);
      logic [20:0] v;
      if (is_direct(cp)) begin
        flush_held();
        if (in_run) begin
          if (is_b64(cp) || cp == CH_DASH) push_char(CH_DASH);
          in_run = 1'b0;
        end
        push_char(cp[6:0]);
      end else if (cp == CH_PLUS && !in_run) begin
        push_char(CH_PLUS);
        push_char(CH_DASH);
      end else if (cp > 21'h10FFFF) begin
        put_unit(16'hFFFD);
      end else if (cp >= 21'h10000) begin
        v = cp - 21'h10000;
        put_unit(16'hD800 + {6'd0, v[19:10]});
        put_unit(16'hDC00 + {6'd0, v[9:0]});
      end else begin
        put_unit(cp[15:0]);
      end
    endfunction

    function int cont_count(logic [7:0] b);
      if (b <= 8'h7F) return 0;
      if (b <= 8'hDF) return 1;
      if (b <= 8'hEF) return 2;
      return 3;
    endfunction

    function logic [20:0] decode(logic [7:0] lead, logic [7:0] c0, logic [7:0] c1,
                                 logic [7:0] c2, int n);
      if (n == 1) return {10'd0, lead[4:0], c0[5:0]};
      if (n == 2) return {5'd0, lead[3:0], c0[5:0], c1[5:0]};
      return {lead[2:0], c0[5:0], c1[5:0], c2[5:0]};
    endfunction

    // Accepted input request: update the encoder state, queue its characters.
    function void note_byte(logic [7:0] b, logic is_last);
      logic [7:0] c[3];
      logic [7:0] tail[3];
      int         n;
      int         pos;
      int         k;
      int         i;
      step_chars.delete();
      if (cont_needed == 0) begin
        n = cont_count(b);
        if (n == 0) begin
          put_code({13'd0, b});
        end else begin
          seq_lead_cont[0] = b;
          cont_needed = n;
          cont_have   = 0;
        end
      end else if (cont_have + 1 >= cont_needed) begin
        c = '{8'h00, 8'h00, 8'h00};
        for (i = 0; i < cont_have && i < 2; i++) c[i] = seq_lead_cont[1 + i];
        c[(cont_have < 2) ? cont_have : 2] = b;
        put_code(decode(seq_lead_cont[0], c[0], c[1], c[2], cont_needed));
        cont_needed = 0;
        cont_have   = 0;
      end else begin
        seq_lead_cont[1 + (cont_have & 1)] = b;
        cont_have++;
      end

      if (is_last) begin
        // Sequence cut short: lead becomes its own unit, the rest is re-parsed.
        if (cont_needed != 0) begin
          n = 1 + ((cont_have < 2) ? cont_have : 2);
          tail = seq_lead_cont;
          cont_needed = 0;
          cont_have   = 0;
          pos = 0;
          while (pos < n) begin
            k = cont_count(tail[pos]);
            if (k > 0 && k <= n - pos - 1) begin
              put_code(decode(tail[pos], tail[(pos + 1) % 3], tail[(pos + 2) % 3],
                              tail[(pos + 3) % 3], k));
              pos += k + 1;
            end else begin
              put_code({13'd0, tail[pos]});
              pos++;
            end
          end
        end
        flush_held();
        if (in_run) push_char(CH_DASH);
        in_run = 1'b0;
      end

      if (step_chars.size() > 0) step_chars[step_chars.size() - 1].is_last = 1'b1;
      foreach (step_chars[j]) expected_chars.push_back(step_chars[j]);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_char(logic [6:0] ch, logic is_last);
      utf7_char_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, is_last));
      end else begin
        want = expected_chars.pop_front();
        if (ch !== want.ch)
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
        if (is_last !== want.is_last)
          report_mismatch($sformatf("last %0b, want %0b (char 0x%02h)",
                                    is_last, want.is_last, want.ch));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [6:0] out_char_o;
  logic       out_last_o;

  utf8_to_utf7_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  utf7_char_scoreboard sb = new();

  // Idle odds in percent, per side; changed between phases.
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 81;
  int unsigned bytes_sent    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: ready changes on the falling edge only, so the rising edge
  // always sees a settled value.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every character taken by the receiver is checked against the oldest
  // expectation. The output stage is registered, so a character never
  // belongs to a request accepted on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_char(out_char_o, out_last_o);
  end

  // One input request. Valid goes up at a falling edge (after a random gap)
  // and stays up with the same payload until the block takes it. The caller's
  // next falling edge either loads the next request or drops valid.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = b;
    in_last_i  = is_last;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_byte(b, is_last);
    bytes_sent++;
  endtask

  // Sender holds off until every expected character has come out, then
  // gives the block time to finish anything that produced no character yet.
  task automatic drain_output();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Continuation byte: mostly well formed, now and then any byte at all
  // (continuations are not checked by the block).
  function automatic logic [7:0] rand_cont();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  function automatic logic [7:0] rand_ascii();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(8))
          0: return {1'b0, CH_CR};
          1: return {1'b0, CH_LF};
          2: return {1'b0, CH_DQUOTE};
          3: return {1'b0, CH_PLUS};
          4: return {1'b0, CH_DASH};
          5: return {1'b0, CH_EQUALS};
          6: return {1'b0, CH_BSLASH};
          7: return {1'b0, CH_TILDE};
          default: return 8'h7F;
        endcase
      end
      1: return 8'($urandom_range(8'h41, 8'h5A)) | (($urandom_range(1) == 1) ? 8'h20 : 8'h00);
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  // One random string: mostly whole UTF-8 sequences with random content,
  // some noise bytes; one string in five is cut off, often mid-sequence.
  task automatic send_random_text(input int unsigned target);
    logic [7:0] text[$];
    int         nc;
    int         kind;
    bit         cut;
    logic [7:0] lead;
    cut = ($urandom_range(4) == 0);
    while (text.size() < target) begin
      kind = $urandom_range(9);
      nc = 0;
      if (kind <= 3) begin
        lead = rand_ascii();
      end else if (kind <= 5) begin
        lead = ($urandom_range(3) == 0) ? 8'($urandom_range(8'h80, 8'hC1))
                                        : 8'($urandom_range(8'hC2, 8'hDF));
        nc = 1;
      end else if (kind <= 7) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        nc = 2;
      end else if (kind == 8) begin
        lead = ($urandom_range(3) == 0) ? 8'($urandom_range(8'hF5, 8'hFF))
                                        : 8'($urandom_range(8'hF0, 8'hF4));
        nc = 3;
      end else begin
        lead = 8'($urandom_range(255));
      end
      text.push_back(lead);
      for (int j = 0; j < nc; j++) text.push_back(rand_cont());
    end
    if (cut) text = text[0:target - 1];
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    in_last_i  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, sender and receiver on the first phase's odds.
    send_byte(8'h41, 1'b0);              // plain direct char
    send_byte({1'b0, CH_PLUS}, 1'b0);    // plus outside a run -> "+-"
    send_byte(8'h00, 1'b0);              // zero byte is a normal char
    send_byte(8'h7F, 1'b0);              // DEL opens a base64 run
    send_byte({1'b0, CH_PLUS}, 1'b0);    // plus inside a run is a unit
    send_byte({1'b0, CH_DASH}, 1'b0);    // dash closes run with extra dash
    send_byte({1'b0, CH_CR}, 1'b0);
    send_byte({1'b0, CH_LF}, 1'b0);
    send_byte({1'b0, CH_TILDE}, 1'b0);
    send_byte({1'b0, CH_EQUALS}, 1'b0);
    send_byte({1'b0, CH_BSLASH}, 1'b0);
    send_byte({1'b0, CH_DQUOTE}, 1'b0);
    send_byte(8'h2E, 1'b0);              // non-base64 direct: no dash
    send_byte(8'hC3, 1'b0);              // two-byte form
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);              // three-byte form
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);              // four-byte form -> surrogate pair
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);              // above 0x10FFFF -> 0xFFFD
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);              // end of string inside a run
    send_byte(8'hC1, 1'b0);              // overlong 'A'
    send_byte(8'h81, 1'b0);
    send_byte(8'hE2, 1'b0);              // cut short by the end
    send_byte(8'h82, 1'b1);
    drain_output();

    // Random part in three idling phases, pausing for a full drain between.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_random_text($urandom_range(1, 14));
      drain_output();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
